// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LCFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// The condition must never be true outside reset.
`define LCFP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `LCFP_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ===== rtl/core/lcfp_pkg.sv =====
package lcfp_pkg;

  localparam int FracBits    = 8;
  localparam int CordicSteps = 18;
  localparam int SlopeShift  = 16 - FracBits;
  localparam int VecShift    = 20 - FracBits;
  localparam int PixScale    = 50 << (16 - FracBits);
  localparam int MidCentre   = 60 << FracBits;
  localparam int PixDen      = 77;

  localparam logic [7:0] HdrByte = 8'hF5;
  localparam logic [7:0] IdByte  = 8'h02;

  typedef struct packed {
    logic        [15:0] upper;
    logic        [15:0] middle;
    logic        [7:0]  frames;
    logic        [11:0] height;
    logic signed [15:0] roll;
  } frame_t;

  function automatic logic signed [31:0] atan_q16(logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd2949120;
      5'd1:    v = 32'sd1740967;
      5'd2:    v = 32'sd919879;
      5'd3:    v = 32'sd466945;
      5'd4:    v = 32'sd234379;
      5'd5:    v = 32'sd117304;
      5'd6:    v = 32'sd58666;
      5'd7:    v = 32'sd29335;
      5'd8:    v = 32'sd14668;
      5'd9:    v = 32'sd7334;
      5'd10:   v = 32'sd3667;
      5'd11:   v = 32'sd1833;
      5'd12:   v = 32'sd917;
      5'd13:   v = 32'sd458;
      5'd14:   v = 32'sd229;
      5'd15:   v = 32'sd115;
      5'd16:   v = 32'sd57;
      5'd17:   v = 32'sd29;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lcfp_front.sv =====
module lcfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [11:0]         height_cm_i,
  input  logic signed [15:0]  roll_angle_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output lcfp_pkg::frame_t    q_frame_o
);
  import lcfp_pkg::*;

  typedef enum logic [1:0] {PhHdr, PhId, PhRow0, PhRow1} phase_e;

  phase_e      phase_q;
  logic [7:0]  first_q;
  logic [15:0] upper_q, middle_q, upper_d, middle_d;
  logic [7:0]  count_q;
  logic        accept;

  // One filter step: old + round((row - old) / 5), ties away from zero.
  function automatic logic [15:0] filt(logic [15:0] old, logic [7:0] row);
    logic signed [17:0] diff;
    logic [16:0]        mag;
    logic [33:0]        prod;
    logic [15:0]        stp;
    diff = $signed(18'(16'(row) << FracBits)) - $signed({2'b00, old});
    mag  = diff[17] ? 17'(-diff) + 17'd2 : 17'(diff) + 17'd2;
    prod = 34'(mag) * 34'd52429;
    stp  = prod[33:18];
    return diff[17] ? old - stp : old + stp;
  endfunction

  assign accept   = push_i && !q_full_i;
  assign upper_d  = filt(upper_q, first_q);
  assign middle_d = filt(middle_q, rx_byte_i);
  assign q_push_o = accept && (phase_q == PhRow1);

  always_comb begin
    q_frame_o.upper  = upper_d;
    q_frame_o.middle = middle_d;
    q_frame_o.frames = count_q + 8'd1;
    q_frame_o.height = height_cm_i;
    q_frame_o.roll   = roll_angle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr;
      first_q  <= '0;
      upper_q  <= '0;
      middle_q <= '0;
      count_q  <= '0;
    end else if (accept) begin
      case (phase_q)
        PhHdr:  phase_q <= (rx_byte_i == HdrByte) ? PhId : PhHdr;
        PhId:   phase_q <= (rx_byte_i == IdByte) ? PhRow0 : PhHdr;
        PhRow0: begin
          first_q <= rx_byte_i;
          phase_q <= PhRow1;
        end
        default: begin
          phase_q  <= PhHdr;
          upper_q  <= upper_d;
          middle_q <= middle_d;
          count_q  <= count_q + 8'd1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lcfp_fifo.sv =====
`include "assert_macros.svh"

module lcfp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lcfp_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lcfp_pkg::frame_t data_o
);
  import lcfp_pkg::*;

  frame_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `LCFP_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `LCFP_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o)
  `LCFP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2)

endmodule

// ===== rtl/core/lcfp_div.sv =====
module lcfp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [47:0] quot_o
);
  logic [31:0] rem_q, dvs_q;
  logic [47:0] quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial  = {rem_q, quo_q[47]};
  assign diff   = trial - {1'b0, dvs_q};
  assign ge     = (trial >= {1'b0, dvs_q});
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd47;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[31:0] : trial[31:0];
        quo_q <= {quo_q[46:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lcfp_back.sv =====
`include "assert_macros.svh"

module lcfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  lcfp_pkg::frame_t   q_frame_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [15:0]        upper_o,
  output logic [15:0]        middle_o,
  output logic signed [15:0] slope_o,
  output logic signed [15:0] with_roll_o,
  output logic signed [15:0] without_roll_o,
  output logic [7:0]         frames_o
);
  import lcfp_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SVec, SSlope, SPixWait, SScale, SRound, SWrap, SRot,
    SMul, SOffDiv, SOffWait, SStore, SDone
  } state_e;

  localparam logic signed [26:0] Deg90  = 27'sd5898240;
  localparam logic signed [26:0] Deg180 = 27'sd11796480;
  // The ceiling of 2^37 / 77, exact as a floor division for numerators below 2^30.
  localparam logic [30:0]        PixRecip = 31'd1784921474;

  state_e             st_q;
  frame_t             fr_q;
  logic [4:0]         step_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic signed [15:0] slope_q, off_q, with_q, held_q;
  logic signed [24:0] pix_q;
  logic signed [26:0] ang_q;
  logic signed [44:0] prod_q;
  logic signed [46:0] hy_q;
  logic               neg_q, pass_q, out_valid_q;

  logic signed [33:0] xs, ys;
  logic signed [31:0] at;
  logic signed [17:0] dmid;
  logic [16:0]        dmag;
  logic [45:0]        hmag;
  logic signed [26:0] ang_in, rnd;
  logic signed [31:0] srnd;
  logic [44:0]        pmag;
  logic               div_start, div_busy, div_done;
  logic [47:0]        div_num, div_quot;
  logic signed [15:0] sat_val;
  logic signed [16:0] vdiff;
  logic [30:0]        pnum;
  logic [61:0]        pprod;

  assign xs   = cx_q >>> step_q;
  assign ys   = cy_q >>> step_q;
  assign at   = atan_q16(step_q);
  assign dmid = $signed({2'b00, fr_q.middle}) - 18'(MidCentre);
  assign dmag = dmid[17] ? 17'(-dmid) : 17'(dmid);
  assign pnum = 31'(dmag) * 31'(PixScale);
  assign pprod = 62'(pnum + 31'(PixDen / 2)) * 62'(PixRecip);
  assign hmag = hy_q[46] ? 46'(-hy_q) : 46'(hy_q);
  assign vdiff = $signed({1'b0, q_frame_i.upper}) - $signed({1'b0, q_frame_i.middle});

  assign ang_in = pass_q ? 27'(pix_q)
                         : 27'(pix_q) + 27'($signed({fr_q.roll, 8'h00}));
  assign pmag   = prod_q[44] ? 45'(-prod_q) : 45'(prod_q);
  assign rnd    = prod_q[44] ? -$signed(27'((pmag + 45'd32768) >> 16))
                             : $signed(27'((pmag + 45'd32768) >> 16));
  assign srnd   = cz_q[31]
                  ? -$signed(32'((32'(-cz_q) + (32'd1 << (SlopeShift - 1))) >> SlopeShift))
                  : $signed(32'((32'(cz_q) + (32'd1 << (SlopeShift - 1))) >> SlopeShift));

  always_comb begin
    if (neg_q) begin
      sat_val = (div_quot > 48'd32768) ? 16'sh8000 : -$signed(div_quot[15:0]);
    end else begin
      sat_val = (div_quot > 48'd32767) ? 16'sd32767 : $signed(div_quot[15:0]);
    end
  end

  assign div_start = (st_q == SOffDiv) && (fr_q.height != '0) && (cx_q > 34'sd0);
  assign div_num   = 48'(hmag) + 48'(cx_q[31:1]);

  lcfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (cx_q[31:0]),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign q_pop_o        = (st_q == SIdle) && !q_empty_i;
  assign empty_o        = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SIdle;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      step_q      <= '0;
      pass_q      <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      if (pop_i && out_valid_q && (st_q != SDone)) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        SIdle: begin
          if (!q_empty_i) begin
            fr_q   <= q_frame_i;
            st_q   <= SVec;
            step_q <= '0;
            cx_q   <= 34'sd50 <<< 20;
            cy_q   <= 34'(vdiff) <<< VecShift;
            cz_q   <= '0;
          end
        end
        SVec: begin
          if (cy_q > 34'sd0) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + at;
          end else if (cy_q < 34'sd0) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - at;
          end
          step_q <= step_q + 5'd1;
          if (step_q == 5'(CordicSteps - 1)) begin
            st_q <= SSlope;
          end
        end
        SSlope: begin
          slope_q <= 16'(srnd);
          pass_q  <= 1'b0;
          neg_q   <= dmid[17];
          if (fr_q.middle == '0) begin
            with_q <= '0;
            st_q   <= SDone;
          end else begin
            st_q <= SPixWait;
          end
        end
        SPixWait: begin
          pix_q <= neg_q ? -$signed(pprod[61:37]) : $signed(pprod[61:37]);
          st_q  <= SScale;
        end
        SScale: begin
          prod_q <= 45'(ang_in) * 45'sd65524;
          st_q   <= SRound;
        end
        SRound: begin
          ang_q <= rnd;
          st_q  <= SWrap;
        end
        SWrap: begin
          if (ang_q > Deg90) begin
            ang_q <= ang_q - Deg180;
          end else if (ang_q < -Deg90) begin
            ang_q <= ang_q + Deg180;
          end else begin
            cx_q   <= 34'sd1 <<< 30;
            cy_q   <= '0;
            cz_q   <= 32'(ang_q);
            step_q <= '0;
            st_q   <= SRot;
          end
        end
        SRot: begin
          if (!cz_q[31]) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - at;
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + at;
          end
          step_q <= step_q + 5'd1;
          if (step_q == 5'(CordicSteps - 1)) begin
            st_q <= SMul;
          end
        end
        SMul: begin
          hy_q <= $signed({1'b0, fr_q.height}) * cy_q;
          st_q <= SOffDiv;
        end
        SOffDiv: begin
          neg_q <= hy_q[46];
          if (fr_q.height == '0) begin
            off_q <= '0;
            st_q  <= SStore;
          end else if (cx_q <= 34'sd0) begin
            off_q <= cy_q[33] ? 16'sh8000 : 16'sd32767;
            st_q  <= SStore;
          end else begin
            st_q <= SOffWait;
          end
        end
        SOffWait: begin
          if (div_done) begin
            off_q <= sat_val;
            st_q  <= SStore;
          end
        end
        SStore: begin
          if (!pass_q) begin
            with_q <= off_q;
            pass_q <= 1'b1;
            st_q   <= SScale;
          end else begin
            held_q <= off_q;
            st_q   <= SDone;
          end
        end
        SDone: begin
          if (!out_valid_q || pop_i) begin
            upper_o        <= fr_q.upper;
            middle_o       <= fr_q.middle;
            slope_o        <= slope_q;
            with_roll_o    <= with_q;
            without_roll_o <= held_q;
            frames_o       <= fr_q.frames;
            out_valid_q    <= 1'b1;
            st_q           <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  `LCFP_ASSERT_NEVER(a_div_start_busy, clk_i, rst_ni, div_start && div_busy)
  `LCFP_ASSERT(a_done_in_wait, clk_i, rst_ni, !div_done || (st_q == SOffWait))
  `LCFP_ASSERT(a_step_range, clk_i, rst_ni, step_q <= 5'(CordicSteps))

endmodule

// ===== rtl/core/line_camera_frame_parser_top.sv =====
// Camera link frame parser: bytes are taken one per cycle whenever full is low, and a frame
// (F5h, 02h, upper row, middle row) is handed to a two-entry frame queue on its last byte.
// Each queued frame is then processed by the shared serial divider (used up to twice per
// frame) and the 18-step CORDIC (run up to three times); a result waits in the output
// register until popped while the next frame is already being worked on.
module line_camera_frame_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic [11:0]        height_cm_i,
  input  logic signed [15:0] roll_angle_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        upper_row_smoothed_o,
  output logic [15:0]        middle_row_smoothed_o,
  output logic signed [15:0] slope_degrees_o,
  output logic signed [15:0] offset_with_roll_o,
  output logic signed [15:0] offset_without_roll_o,
  output logic [7:0]         frames_seen_o
);
  import lcfp_pkg::*;

  frame_t in_frame, out_frame;
  logic   q_push, q_full, q_pop, q_empty;

  assign full = q_full;

  lcfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .rx_byte_i    (rx_byte_i),
    .height_cm_i  (height_cm_i),
    .roll_angle_i (roll_angle_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_frame_o    (in_frame)
  );

  lcfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (in_frame),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (out_frame)
  );

  lcfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_frame_i      (out_frame),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .upper_o        (upper_row_smoothed_o),
    .middle_o       (middle_row_smoothed_o),
    .slope_o        (slope_degrees_o),
    .with_roll_o    (offset_with_roll_o),
    .without_roll_o (offset_without_roll_o),
    .frames_o       (frames_seen_o)
  );

endmodule

// ===== tb/frame_checker.sv =====
module frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic [11:0]        height_cm_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [15:0]        upper_row_smoothed_o,
  input  logic [15:0]        middle_row_smoothed_o,
  input  logic signed [15:0] slope_degrees_o,
  input  logic signed [15:0] offset_with_roll_o,
  input  logic signed [15:0] offset_without_roll_o,
  input  logic [7:0]         frames_seen_o,
  output int                 fail_count,
  output int                 pending_count,
  output int                 frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcfp_pkg::*;

  typedef struct packed {
    logic [15:0] upper;
    logic [15:0] middle;
    logic [15:0] slope;
    logic [15:0] with_roll;
    logic [15:0] no_roll;
    logic [7:0]  frames;
  } line_estimate_t;

  typedef enum logic [1:0] {
    AwaitHeader = 2'd0,
    AwaitId     = 2'd1,
    AwaitUpper  = 2'd2,
    AwaitMiddle = 2'd3
  } phase_e;

  localparam longint Deg180 = 64'sd11796480;

  line_estimate_t estimate_q[$];
  phase_e  phase;
  logic [7:0]  held_upper;
  longint  upper_f, middle_f, held_no_roll;
  logic [7:0]  frame_count;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint atan_vector(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += longint'(atan_q16(5'(i)));
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= longint'(atan_q16(5'(i)));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint lateral_offset(longint height, longint ang);
    longint x, y, nx, ny, q;
    x = 64'sd1 <<< 30;
    y = 0;
    ang = round_div(ang * 65524, 65536);
    while (ang > Deg180 / 2) ang -= Deg180;
    while (ang < -Deg180 / 2) ang += Deg180;
    for (int i = 0; i < CordicSteps; i++) begin
      if (ang >= 0) begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        ang -= longint'(atan_q16(5'(i)));
      end else begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        ang += longint'(atan_q16(5'(i)));
      end
      x = nx;
      y = ny;
    end
    if (height == 0) return 0;
    if (x <= 0) return (y >= 0) ? 32767 : -32768;
    q = round_div(height * y, x);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic longint smooth_row(longint old, logic [7:0] row);
    return old + round_div((longint'(row) <<< FracBits) - old, 5);
  endfunction

  task automatic take_byte(logic [7:0] b, logic [11:0] h, logic signed [15:0] r);
    line_estimate_t e;
    longint slope, pix, with_roll;
    case (phase)
      AwaitHeader: phase = (b == HdrByte) ? AwaitId : AwaitHeader;
      AwaitId:     phase = (b == IdByte) ? AwaitUpper : AwaitHeader;
      AwaitUpper: begin
        held_upper = b;
        phase = AwaitMiddle;
      end
      default: begin
        phase = AwaitHeader;
        frame_count++;
        upper_f = smooth_row(upper_f, held_upper);
        middle_f = smooth_row(middle_f, b);
        slope = atan_vector(64'sd50 <<< 20, (upper_f - middle_f) <<< VecShift);
        slope = round_div(slope <<< FracBits, 65536);
        if (middle_f != 0) begin
          pix = round_div((middle_f - MidCentre) * (64'sd1 <<< SlopeShift) * 50, PixDen);
          with_roll = lateral_offset(longint'(h), pix + longint'(r) * 256);
          held_no_roll = lateral_offset(longint'(h), pix);
        end else begin
          with_roll = 0;
        end
        e.upper = upper_f[15:0];
        e.middle = middle_f[15:0];
        e.slope = slope[15:0];
        e.with_roll = with_roll[15:0];
        e.no_roll = held_no_roll[15:0];
        e.frames = frame_count;
        estimate_q.push_back(e);
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_estimate_t e;
    if (!rst_ni) begin
      phase = AwaitHeader;
      held_upper = '0;
      upper_f = 0;
      middle_f = 0;
      held_no_roll = 0;
      frame_count = '0;
      estimate_q.delete();
      fail_count = 0;
      frames_checked = 0;
    end else begin
      if (push && !full) take_byte(rx_byte_i, height_cm_i, roll_angle_i);
      if (pop && !empty) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual frame %0d", $time,
                   frames_seen_o);
          fail_count++;
        end else begin
          e = estimate_q.pop_front();
          compare_field("upper_row_smoothed", e.upper, upper_row_smoothed_o);
          compare_field("middle_row_smoothed", e.middle, middle_row_smoothed_o);
          compare_field("slope_degrees", e.slope, slope_degrees_o);
          compare_field("offset_with_roll", e.with_roll, offset_with_roll_o);
          compare_field("offset_without_roll", e.no_roll, offset_without_roll_o);
          compare_field("frames_seen", {8'd0, e.frames}, {8'd0, frames_seen_o});
          frames_checked++;
        end
      end
    end
    pending_count = estimate_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcfp_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte_i = '0;
  logic [11:0]        height_cm_i = '0;
  logic signed [15:0] roll_angle_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [15:0]        upper_row_smoothed_o, middle_row_smoothed_o;
  logic signed [15:0] slope_degrees_o, offset_with_roll_o, offset_without_roll_o;
  logic [7:0]         frames_seen_o;
  int                 fail_count, pending_count, frames_checked;
  int                 bytes_sent = 0;
  bit                 quiet_tail = 1'b0;
  bit                 hold_results = 1'b0;

  always #1 clk_i = ~clk_i;

  line_camera_frame_parser_top dut (.*);
  frame_checker checker_i (.*);

  task automatic send_byte(logic [7:0] b, logic [11:0] h, logic signed [15:0] r);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    height_cm_i <= h;
    roll_angle_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic signed [15:0] any_roll();
    case ($urandom_range(0, 5))
      0: return -16'sd23040;
      1: return 16'sd23040;
      2: return 16'sd0;
      default: return $signed(16'($urandom_range(0, 46080) - 23040));
    endcase
  endfunction

  function automatic logic [11:0] any_height();
    case ($urandom_range(0, 4))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_frame(logic [7:0] up, logic [7:0] mid, logic [11:0] h,
                            logic signed [15:0] r);
    send_byte(HdrByte, h, r);
    send_byte(IdByte, h, r);
    send_byte(up, h, r);
    send_byte(mid, h, r);
  endtask

  always @(posedge clk_i) begin
    int gap;
    if (!rst_ni || hold_results) begin
      pop <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap - 1) @(posedge clk_i);
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_frame(8'd0, 8'd0, 12'd100, 16'sd0);
    send_frame(8'd255, 8'd255, 12'hFFF, 16'sd23040);
    send_frame(8'd0, 8'd255, 12'hFFF, -16'sd23040);
    send_frame(8'd255, 8'd0, 12'd0, 16'sd0);
    send_byte(8'h00, 12'd1, 16'sd0);
    send_byte(HdrByte, 12'd1, 16'sd0);
    send_byte(8'h03, 12'd1, 16'sd0);
    send_byte(IdByte, 12'd1, 16'sd0);
    send_frame(8'd60, 8'd60, 12'd500, 16'sd256);
    hold_results <= 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk_i);
        hold_results <= 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_frame(8'($urandom), 8'($urandom), any_height(), any_roll());
    join
    while (bytes_sent < 1950) begin
      if (bytes_sent > 1700) quiet_tail = 1'b1;
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_frame(8'($urandom), 8'($urandom), any_height(), any_roll());
      end else if (r == 7) begin
        send_byte(HdrByte, any_height(), any_roll());
        send_byte(8'($urandom), any_height(), any_roll());
      end else begin
        send_byte(8'($urandom), any_height(), any_roll());
      end
    end
    push <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d bytes and checked %0d frames, with header faults and a long", bytes_sent,
             frames_checked);
    $display("result stall that filled the frame queue.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lcfp_pkg.sv
rtl/core/lcfp_front.sv
rtl/core/lcfp_fifo.sv
rtl/core/lcfp_div.sv
rtl/core/lcfp_back.sv
rtl/core/line_camera_frame_parser_top.sv
tb/frame_checker.sv
tb/testbench.sv
